// ===== rtl/wace_pkg.sv =====
// Package for the window-aware cache evictor: payload structs, register codes,
// controller/datapath command and status types. No dependencies.
package wace_pkg;

  localparam int TableDepth = 16;
  localparam int SlotBits   = $clog2(TableDepth);
  localparam int IndexBits  = 16;
  localparam int TotalBits  = 41;
  localparam int BudgetBits = 40;
  localparam int SizeBits   = 32;
  localparam int CfgBits    = 40;

  localparam logic [1:0] RegBudget = 2'd0;
  localparam logic [1:0] RegBefore = 2'd1;
  localparam logic [1:0] RegAfter  = 2'd2;
  localparam logic [1:0] RegCount  = 2'd3;

  localparam logic OpRequest  = 1'b0;
  localparam logic OpComplete = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [IndexBits-1:0] image_index;
    logic [SizeBits-1:0]  byte_count;
    logic [IndexBits-1:0] current_index;
    logic                 moving_forward;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 table_full;
    logic                 evicted;
    logic [IndexBits-1:0] evicted_index;
    logic [TotalBits-1:0] total_bytes;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic load;       // capture input item
    logic lookup;     // scan step of lookup pass
    logic apply;      // apply request / completion
    logic scan_clr;   // start victim scan
    logic scan_step;  // remainder step or examine one entry
    logic evict;      // remove chosen victim
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;  // last entry examined
    logic over;       // total exceeds budget
    logic any_valid;  // victim found
    logic found;      // completion found its entry
    logic op;
  } dp_sts_t;

endpackage

// ===== rtl/wace_datapath.sv =====
// Datapath of the evictor: entry table, running total, lookup scan (one entry
// per cycle) and victim scan. Depends on wace_pkg.
module wace_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [wace_pkg::CfgBits-1:0]    cfg_data,
  input  wace_pkg::in_item_t              item,
  input  wace_pkg::dp_cmd_t               cmd,
  output wace_pkg::dp_sts_t               sts,
  output logic                            hit,
  output logic                            table_full,
  output logic [wace_pkg::IndexBits-1:0]  victim_index,
  output logic [wace_pkg::TotalBits-1:0]  total
);

  localparam int SB = wace_pkg::SlotBits;
  localparam int IB = wace_pkg::IndexBits;
  localparam int RB = $clog2(IB + 1);
  localparam int PB = $clog2(IB);

  logic [wace_pkg::BudgetBits-1:0] budget_r;
  logic [IB-1:0] before_r, after_r, count_r;

  logic [wace_pkg::TableDepth-1:0] valid_r;
  logic [IB-1:0] idx_mem [wace_pkg::TableDepth];
  logic [wace_pkg::SizeBits-1:0] bytes_mem [wace_pkg::TableDepth];
  logic [wace_pkg::TotalBits-1:0] total_r;

  wace_pkg::in_item_t item_r;
  logic [SB:0] ptr_r;
  logic [SB-1:0] slot_r, free_r, best_r, low_r;
  logic slot_ok_r, free_ok_r, best_ok_r, low_ok_r;
  logic [IB-1:0] best_dist_r;
  logic [IB-1:0] cur_mod_r, start_r, end_r;
  logic hit_r, full_r;

  logic [SB-1:0] p;
  logic [IB-1:0] e_idx, e_mod, d, best_idx, low_idx;
  logic in_win, better;

  // remainder by image_count: current, before, after, then each entry
  logic [IB-1:0] rem_r;
  logic [RB-1:0] rbit_r;
  logic reducing_r;
  logic [2:0] rphase_r;
  logic [IB-1:0] rsrc;
  logic [PB-1:0] rpos;
  logic [IB:0] rtrial;

  // reduce x mod n where x < 2n
  function automatic logic [IB-1:0] red2(input logic [IB:0] x, input logic [IB-1:0] n);
    logic [IB:0] t;
    t = x - {1'b0, n};
    red2 = (x >= {1'b0, n}) ? t[IB-1:0] : x[IB-1:0];
  endfunction

  assign p = ptr_r[SB-1:0];
  assign e_idx = idx_mem[p];
  assign best_idx = idx_mem[best_r];
  assign low_idx = idx_mem[low_r];

  assign e_mod = rem_r;
  always_comb begin
    if (count_r == '0) in_win = 1'b0;
    else if (start_r <= end_r) in_win = (e_idx >= start_r) && (e_idx <= end_r);
    else in_win = (e_idx >= start_r) || (e_idx <= end_r);
    if (count_r == '0) d = '0;
    else if (item_r.moving_forward)
      d = red2({1'b0, cur_mod_r} + {1'b0, count_r} - {1'b0, e_mod}, count_r);
    else
      d = red2({1'b0, e_mod} + {1'b0, count_r} - {1'b0, cur_mod_r}, count_r);
    better = !best_ok_r || (d > best_dist_r) || (d == best_dist_r && e_idx < best_idx);
  end

  // restoring remainder: one bit per cycle
  assign rpos = PB'(rbit_r - 1'b1);
  assign rtrial = {rem_r, rsrc[rpos]} - {1'b0, count_r};

  assign sts.scan_done = reducing_r ? 1'b0 :
                         (ptr_r == (SB+1)'(wace_pkg::TableDepth - 1));
  assign sts.over      = total_r > {1'b0, budget_r};
  assign sts.any_valid = best_ok_r || low_ok_r;
  assign sts.found     = slot_ok_r;
  assign sts.op        = item_r.operation;

  assign hit = hit_r;
  assign table_full = full_r;
  assign victim_index = best_ok_r ? best_idx : low_idx;
  assign total = total_r;

  // rsrc: value currently being reduced
  always_comb begin
    unique case (rphase_r)
      3'd0: rsrc = item_r.current_index;
      3'd1: rsrc = before_r;
      3'd2: rsrc = after_r;
      default: rsrc = e_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0; before_r <= '0; after_r <= '0; count_r <= '0;
      valid_r <= '0; total_r <= '0;
      reducing_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          wace_pkg::RegBudget: budget_r <= cfg_data[wace_pkg::BudgetBits-1:0];
          wace_pkg::RegBefore: before_r <= cfg_data[IB-1:0];
          wace_pkg::RegAfter:  after_r  <= cfg_data[IB-1:0];
          wace_pkg::RegCount:  count_r  <= cfg_data[IB-1:0];
        endcase
      end
      if (cmd.load) begin
        item_r <= item;
        ptr_r <= '0;
        slot_ok_r <= 1'b0; free_ok_r <= 1'b0;
        hit_r <= 1'b0; full_r <= 1'b0;
      end
      if (cmd.lookup) begin
        if (valid_r[p]) begin
          if (!slot_ok_r && e_idx == item_r.image_index) begin
            slot_ok_r <= 1'b1; slot_r <= p;
          end
        end else if (!free_ok_r) begin
          free_ok_r <= 1'b1; free_r <= p;
        end
        ptr_r <= (ptr_r == (SB+1)'(wace_pkg::TableDepth - 1)) ? ptr_r : ptr_r + 1'b1;
      end
      if (cmd.apply) begin
        if (item_r.operation == wace_pkg::OpRequest) begin
          if (slot_ok_r) hit_r <= 1'b1;
          else if (!free_ok_r) full_r <= 1'b1;
          else begin
            valid_r[free_r] <= 1'b1;
            idx_mem[free_r] <= item_r.image_index;
            bytes_mem[free_r] <= '0;
          end
        end else if (slot_ok_r) begin
          total_r <= total_r - {9'd0, bytes_mem[slot_r]} + {9'd0, item_r.byte_count};
          bytes_mem[slot_r] <= item_r.byte_count;
        end
      end
      if (cmd.scan_clr) begin
        ptr_r <= '0;
        best_ok_r <= 1'b0; low_ok_r <= 1'b0; best_dist_r <= '0;
        // reduce current, before, after, then entries
        reducing_r <= 1'b1; rphase_r <= 3'd0;
        rem_r <= '0; rbit_r <= RB'(IB);
      end
      if (cmd.scan_step) begin
        if (reducing_r) begin
          if (count_r == '0 || rbit_r == '0) begin
            unique case (rphase_r)
              3'd0: cur_mod_r <= rem_r;
              3'd1: start_r <= red2({1'b0, cur_mod_r} + {1'b0, count_r} - {1'b0, rem_r}, count_r);
              3'd2: end_r <= red2({1'b0, cur_mod_r} + {1'b0, rem_r}, count_r);
              default: ;
            endcase
            reducing_r <= (rphase_r != 3'd3);
            if (rphase_r != 3'd3) begin
              rphase_r <= rphase_r + 3'd1;
              rem_r <= '0; rbit_r <= RB'(IB);
            end
          end else begin
            rem_r <= rtrial[IB] ? {rem_r[IB-2:0], rsrc[rpos]} : rtrial[IB-1:0];
            rbit_r <= rbit_r - 1'b1;
          end
        end else begin
          if (valid_r[p]) begin
            if (!low_ok_r || e_idx < low_idx) begin
              low_ok_r <= 1'b1; low_r <= p;
            end
            if (!in_win && better) begin
              best_ok_r <= 1'b1; best_r <= p; best_dist_r <= d;
            end
          end
          if (ptr_r != (SB+1)'(wace_pkg::TableDepth - 1)) begin
            ptr_r <= ptr_r + 1'b1;
            reducing_r <= 1'b1; rem_r <= '0; rbit_r <= RB'(IB);
          end
        end
      end
      if (cmd.evict) begin
        valid_r[best_ok_r ? best_r : low_r] <= 1'b0;
        total_r <= total_r - {9'd0, bytes_mem[best_ok_r ? best_r : low_r]};
      end
    end
  end

endmodule

// ===== rtl/wace_ctrl.sv =====
// Controller of the evictor: sequences lookup, apply, victim scans and result
// delivery. Depends on wace_pkg.
module wace_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  wace_pkg::dp_sts_t  sts,
  output wace_pkg::dp_cmd_t  cmd,
  output logic               res_evicted,
  output logic               res_last
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOK   = 7'b0000010,
    S_APPLY  = 7'b0000100,
    S_FIRST  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_EVICT  = 7'b0100000,
    S_EVOUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [wace_pkg::SlotBits:0] look_r, look_nxt;
  logic [wace_pkg::SlotBits:0] ev_r, ev_nxt;

  always_comb begin
    state_nxt = state_r;
    look_nxt = look_r;
    ev_nxt = ev_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    res_evicted = 1'b0;
    res_last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1; look_nxt = '0; state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        look_nxt = look_r + 1'b1;
        if (look_r == (wace_pkg::SlotBits+1)'(wace_pkg::TableDepth - 1)) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1; state_nxt = S_FIRST;
      end
      S_FIRST: begin
        out_valid = 1'b1;
        res_last = !(sts.op && sts.found && sts.over);
        if (!out_stall) begin
          ev_nxt = '0;
          if (res_last) state_nxt = S_IDLE;
          else begin
            cmd.scan_clr = 1'b1; state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        if (!sts.any_valid) state_nxt = S_IDLE;
        else begin
          cmd.evict = 1'b1; ev_nxt = ev_r + 1'b1; state_nxt = S_EVOUT;
        end
      end
      default: begin
        out_valid = 1'b1;
        res_evicted = 1'b1;
        res_last = !sts.over || ev_r == (wace_pkg::SlotBits+1)'(wace_pkg::TableDepth);
        if (!out_stall) begin
          if (res_last) state_nxt = S_IDLE;
          else begin
            cmd.scan_clr = 1'b1; state_nxt = S_SCAN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; look_r <= '0; ev_r <= '0;
    end else begin
      state_r <= state_nxt; look_r <= look_nxt; ev_r <= ev_nxt;
    end
  end

endmodule

// ===== rtl/window_aware_cache_evictor_top.sv =====
// Usage: in_* takes one item (request or completion); out_* returns one result
// for the operation, then one per eviction, the final one flagged last.
// Lookup walks the 16 entries one per cycle, then apply; the first result is
// shown after apply, and an item with no eviction keeps in_stall high until
// that result is taken.
// Each eviction rescans the table. Every value is reduced mod image_count by a
// 16-step restoring remainder: the current index, before and after for the
// window bounds, then each entry before it is examined; the remainder steps
// are skipped when image_count is 0. Each scan starts once the previous
// result is taken. Up to 16 evictions per item, counted by the controller.
// One item at a time: in_stall stays high until the last result is taken.
// A result holds steady while out_stall is high; the block waits for it.
// Reset (rst_n low, synchronous) empties the table, clears the total and the
// configuration. Write configuration only while idle via cfg_wr_en/cfg_index.
// Depends on wace_pkg, wace_ctrl, wace_datapath.
module window_aware_cache_evictor_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [wace_pkg::CfgBits-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  wace_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output wace_pkg::out_item_t          out_item
);

  wace_pkg::dp_cmd_t cmd;
  wace_pkg::dp_sts_t sts;
  logic hit, full, res_ev, res_last;
  logic [wace_pkg::IndexBits-1:0] vidx;
  logic [wace_pkg::TotalBits-1:0] total;

  wace_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .res_evicted(res_ev), .res_last
  );

  wace_datapath u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .item(in_item), .cmd, .sts,
    .hit, .table_full(full), .victim_index(vidx), .total
  );

  // evicted result is shown after the evict write; keep victim index latched
  logic [wace_pkg::IndexBits-1:0] ev_idx_r;
  always_ff @(posedge clk) begin
    if (cmd.evict) ev_idx_r <= vidx;
  end

  always_comb begin
    out_item.hit           = res_ev ? 1'b0 : hit;
    out_item.table_full    = res_ev ? 1'b0 : full;
    out_item.evicted       = res_ev;
    out_item.evicted_index = res_ev ? ev_idx_r : '0;
    out_item.total_bytes   = total;
    out_item.last          = res_last;
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for window_aware_cache_evictor_top: random requests and
// completions against an in-bench table model. Depends on wace_pkg and the RTL.
module tb_top;

  localparam int WatchdogLimit = 40000;
  localparam int TableDepth = wace_pkg::TableDepth;
  localparam int IndexBits  = wace_pkg::IndexBits;
  localparam int SizeBits   = wace_pkg::SizeBits;
  localparam int TotalBits  = wace_pkg::TotalBits;
  localparam int BudgetBits = wace_pkg::BudgetBits;
  localparam int CfgBits    = wace_pkg::CfgBits;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = wace_pkg::RegBudget;
  logic [CfgBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  wace_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wace_pkg::out_item_t out_item;

  window_aware_cache_evictor_top uut (.*);

  always #5 clk = ~clk;

  // model state
  logic [BudgetBits-1:0] budget_r;
  logic [IndexBits-1:0] before_r, after_r, count_r;
  logic slot_valid [TableDepth];
  logic [IndexBits-1:0] slot_index [TableDepth];
  logic [SizeBits-1:0] slot_bytes [TableDepth];
  logic [TotalBits-1:0] total_r;

  wace_pkg::in_item_t pending_items[$];
  wace_pkg::out_item_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0, gap_left = 0;

  function automatic bit win_covers(logic [IndexBits-1:0] idx, logic [IndexBits-1:0] cur);
    longint unsigned n, c, s, e;
    n = count_r;
    if (n == 0) return 1'b0;
    c = cur % n;
    s = (c + n - (before_r % n)) % n;
    e = (c + (after_r % n)) % n;
    if (s <= e) return idx >= s && idx <= e;
    return idx >= s || idx <= e;
  endfunction

  function automatic longint unsigned lag_distance(logic [IndexBits-1:0] idx,
                                                   logic [IndexBits-1:0] cur, logic fwd);
    longint unsigned n;
    n = count_r;
    if (n == 0) return 0;
    if (fwd) return ((cur % n) + n - (idx % n)) % n;
    return ((idx % n) + n - (cur % n)) % n;
  endfunction

  function automatic void push_result(logic h, logic f, logic ev, logic [IndexBits-1:0] ei);
    wace_pkg::out_item_t r;
    r.hit = h;
    r.table_full = f;
    r.evicted = ev;
    r.evicted_index = ev ? ei : '0;
    r.total_bytes = total_r;
    r.last = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void queue_item(wace_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void predict_evictions(wace_pkg::in_item_t it);
    int slot, free_slot, best, lowest, v, g;
    longint unsigned best_d, d;
    slot = -1;
    free_slot = -1;
    for (int i = 0; i < TableDepth; i++) begin
      if (slot_valid[i]) begin
        if (slot < 0 && slot_index[i] == it.image_index) slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (it.operation == wace_pkg::OpRequest) begin
      if (slot < 0 && free_slot >= 0) begin
        slot_valid[free_slot] = 1'b1;
        slot_index[free_slot] = it.image_index;
        slot_bytes[free_slot] = '0;
      end
      push_result(slot >= 0, slot < 0 && free_slot < 0, 1'b0, '0);
    end else begin
      if (slot >= 0) begin
        total_r = total_r - slot_bytes[slot] + it.byte_count;
        slot_bytes[slot] = it.byte_count;
      end
      push_result(1'b0, 1'b0, 1'b0, '0);
      if (slot >= 0) begin
        for (g = 0; g < TableDepth && total_r > budget_r; g++) begin
          best = -1;
          lowest = -1;
          best_d = 0;
          for (int i = 0; i < TableDepth; i++) begin
            if (!slot_valid[i]) continue;
            if (lowest < 0 || slot_index[i] < slot_index[lowest]) lowest = i;
            if (win_covers(slot_index[i], it.current_index)) continue;
            d = lag_distance(slot_index[i], it.current_index, it.moving_forward);
            if (best < 0 || d > best_d ||
                (d == best_d && slot_index[i] < slot_index[best])) begin
              best = i;
              best_d = d;
            end
          end
          if (lowest < 0) break;
          v = (best >= 0) ? best : lowest;
          total_r = total_r - slot_bytes[v];
          slot_valid[v] = 1'b0;
          push_result(1'b0, 1'b0, 1'b1, slot_index[v]);
        end
      end
    end
    expected_results[$].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_evictions(in_item);
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_items[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(8, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(7, 0) < 3) && ($urandom_range(3, 0) != 0);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", out_item);
          errors++;
        end else begin
          wace_pkg::out_item_t e;
          e = expected_results.pop_front();
          if (out_item.hit !== e.hit)
            $error("hit exp %0d got %0d", e.hit, out_item.hit);
          if (out_item.table_full !== e.table_full)
            $error("table_full exp %0d got %0d", e.table_full, out_item.table_full);
          if (out_item.evicted !== e.evicted)
            $error("evicted exp %0d got %0d", e.evicted, out_item.evicted);
          if (out_item.evicted_index !== e.evicted_index)
            $error("evicted_index exp %0d got %0d", e.evicted_index, out_item.evicted_index);
          if (out_item.total_bytes !== e.total_bytes)
            $error("total_bytes exp %0d got %0d", e.total_bytes, out_item.total_bytes);
          if (out_item.last !== e.last)
            $error("last exp %0d got %0d", e.last, out_item.last);
          if (out_item !== e) errors++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CfgBits-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      wace_pkg::RegBudget: budget_r = val[BudgetBits-1:0];
      wace_pkg::RegBefore: before_r = val[IndexBits-1:0];
      wace_pkg::RegAfter:  after_r = val[IndexBits-1:0];
      wace_pkg::RegCount:  count_r = val[IndexBits-1:0];
    endcase
  endtask

  task automatic settle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic wace_pkg::in_item_t make_item(logic op, logic [IndexBits-1:0] idx,
                                                   logic [SizeBits-1:0] sz,
                                                   logic [IndexBits-1:0] cur, logic fwd);
    wace_pkg::in_item_t it;
    it.operation = op;
    it.image_index = idx;
    it.byte_count = sz;
    it.current_index = cur;
    it.moving_forward = fwd;
    return it;
  endfunction

  // mostly request-then-complete pairs on a small index pool, some noise
  task automatic random_phase(int cnt, int span);
    logic [IndexBits-1:0] idx, cur;
    logic [SizeBits-1:0] sz;
    for (int k = 0; k < cnt; k++) begin
      idx = ($urandom_range(9, 0) == 0) ? IndexBits'($urandom)
                                        : IndexBits'($urandom_range(span, 0));
      cur = ($urandom_range(9, 0) == 0) ? IndexBits'($urandom)
                                        : IndexBits'($urandom_range(span, 0));
      case ($urandom_range(3, 0))
        0: sz = $urandom;
        1: sz = $urandom_range(4000, 0);
        default: sz = $urandom_range(300, 1);
      endcase
      if ($urandom_range(4, 0) != 0) begin
        queue_item(make_item(wace_pkg::OpRequest, idx, '0, cur, 1'($urandom_range(1, 0))));
        queue_item(make_item(wace_pkg::OpComplete, idx, sz, cur, 1'($urandom_range(1, 0))));
        k++;
      end else begin
        queue_item(make_item(1'($urandom_range(1, 0)), idx, $urandom, cur,
                             1'($urandom_range(1, 0))));
      end
    end
  endtask

  initial begin
    total_r = '0;
    budget_r = '0;
    before_r = '0;
    after_r = '0;
    count_r = '0;
    foreach (slot_valid[i]) begin
      slot_valid[i] = 1'b0;
      slot_index[i] = '0;
      slot_bytes[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // zero image count, zero budget: the completion of index 3 evicts only that entry
    queue_item(make_item(wace_pkg::OpComplete, 16'd5, 32'd9, 16'd0, 1'b1));
    queue_item(make_item(wace_pkg::OpRequest, 16'hFFFF, '0, 16'hFFFF, 1'b0));
    queue_item(make_item(wace_pkg::OpRequest, 16'd3, '0, 16'd0, 1'b1));
    queue_item(make_item(wace_pkg::OpRequest, 16'd3, '0, 16'd0, 1'b1));
    queue_item(make_item(wace_pkg::OpComplete, 16'd3, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    settle();

    write_reg(wace_pkg::RegBudget, 40'hFF_FFFF_FFFF);
    write_reg(wace_pkg::RegCount, 40'd20);
    write_reg(wace_pkg::RegBefore, 40'd2);
    write_reg(wace_pkg::RegAfter, 40'd3);
    for (int i = 0; i < 17; i++)
      queue_item(make_item(wace_pkg::OpRequest, IndexBits'(i * 3), '0, 16'd10, 1'b1));
    for (int i = 0; i < 3; i++)
      queue_item(make_item(wace_pkg::OpComplete, IndexBits'(i * 3), 32'hFFFF_FFFF,
                           16'd10, 1'b0));
    queue_item(make_item(wace_pkg::OpComplete, 16'd0, 32'd7, 16'd10, 1'b0));
    settle();
    write_reg(wace_pkg::RegBudget, 40'd0);
    queue_item(make_item(wace_pkg::OpComplete, 16'd6, 32'd1, 16'd1, 1'b1));
    settle();

    write_reg(wace_pkg::RegBudget, 40'd600);
    write_reg(wace_pkg::RegCount, 40'd24);
    write_reg(wace_pkg::RegBefore, 40'd3);
    write_reg(wace_pkg::RegAfter, 40'd4);
    random_phase(70, 30);
    settle();
    write_reg(wace_pkg::RegBudget, 40'd2000);
    write_reg(wace_pkg::RegCount, 40'hFFFF);
    write_reg(wace_pkg::RegBefore, 40'hFFFF);
    write_reg(wace_pkg::RegAfter, 40'd0);
    random_phase(50, 40);
    settle();
    write_reg(wace_pkg::RegBudget, 40'd100);
    write_reg(wace_pkg::RegCount, 40'd7);
    write_reg(wace_pkg::RegBefore, 40'd9);
    write_reg(wace_pkg::RegAfter, 40'hFFFF);
    random_phase(50, 12);
    settle();
    write_reg(wace_pkg::RegBudget, 40'hFF_FFFF_FFFF);
    write_reg(wace_pkg::RegCount, 40'd1);
    write_reg(wace_pkg::RegBefore, 40'd0);
    random_phase(40, 20);
    settle();

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/wace_pkg.sv
rtl/wace_datapath.sv
rtl/wace_ctrl.sv
rtl/window_aware_cache_evictor_top.sv
bench/tb_top.sv
